>>> src/bpr_pkg.sv
// package: shared types, constants and codes for the page replacement block
package bpr_pkg;

  localparam int FRAMES = 16;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int PAGE_W = 31;
  localparam int PIN_W = 16;
  localparam int TOT_W = 32;
  localparam int FRAME_W = 32 + PIN_W + 2;
  localparam logic [31:0] NO_PAGE = 32'hFFFF_FFFF;

  localparam logic [1:0] ACT_PIN = 2'd0;
  localparam logic [1:0] ACT_UNPIN = 2'd1;
  localparam logic [1:0] ACT_DIRTY = 2'd2;
  localparam logic [1:0] ACT_FLUSH = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_NO_ROOM = 2'd2;
  localparam logic [1:0] ST_FLUSH_ERR = 2'd3;

  localparam logic [1:0] STRAT_FIFO = 2'd0;
  localparam logic [1:0] STRAT_LRU = 2'd1;
  localparam logic [1:0] STRAT_CLOCK = 2'd2;

  localparam logic [0:0] REG_STRATEGY = 1'd0;
  localparam logic [0:0] REG_FRAMES = 1'd1;

  typedef struct packed {
    logic [1:0]        action;
    logic [PAGE_W-1:0] page_number;
    logic [PAGE_W-1:0] file_pages;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] frame;
    logic              hit;
    logic              fetch;
    logic              write_back;
    logic [PAGE_W-1:0] write_page;
    logic              last;
    logic [TOT_W-1:0]  reads_total;
    logic [TOT_W-1:0]  writes_total;
  } out_item_t;

  // one frame table entry
  typedef struct packed {
    logic [31:0]      page;
    logic [PIN_W-1:0] pins;
    logic             dirty;
    logic             refb;
  } frame_ent_t;

endpackage

>>> src/bpr_ram.sv
// generic single-port-write ram with registered read
module bpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> src/buffer_pool_page_replacement.sv
// Buffer pool page replacement unit. One transaction at a time is processed by a sequencer
// over the frame table memory, which has a registered read, and an order list held in
// flip-flops. A pin, unpin or mark-dirty scans the order list once, a pin miss may scan
// again for a victim or sweep the clock hand over at most two laps, reading and then
// deciding at each position, and a flush gives one result per dirty unpinned frame, then
// a summary. Result stalls lengthen a transaction. A new transaction is taken only once
// the previous result has left. After reset a clearing pass writes all sixteen table
// entries, and no transaction is taken until it ends.
module buffer_pool_page_replacement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  bpr_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output bpr_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [bpr_pkg::CNT_W-1:0]     cfg_data
);
  localparam int SW = bpr_pkg::SLOT_W;
  localparam int CW = bpr_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_FIND  = 9'b000000100,
    S_VICT  = 9'b000001000,
    S_SWEEP = 9'b000010000,
    S_APPLY = 9'b000100000,
    S_FLUSH = 9'b001000000,
    S_SUM   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] strategy_r;
  logic [CW-1:0] frames_r;
  logic [SW-1:0] order_r [bpr_pkg::FRAMES];
  logic [CW-1:0] occ_r, occ_nxt;
  logic [SW-1:0] hand_r, hand_nxt;
  logic [bpr_pkg::TOT_W-1:0] reads_r, reads_nxt, writes_r, writes_nxt;
  bpr_pkg::in_item_t req_r;
  bpr_pkg::out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [CW-1:0] pos_r, pos_nxt;     // position being issued
  logic [CW-1:0] cpos_r, cpos_nxt;   // position whose data arrives now
  logic rvalid_r, rvalid_nxt;
  logic [CW+1:0] steps_r, steps_nxt;
  logic [CW-1:0] hitpos_r, hitpos_nxt;
  logic found_r, found_nxt;
  logic err_r, err_nxt;
  logic [SW-1:0] clr_r, clr_nxt;

  logic we;
  logic [SW-1:0] waddr, raddr;
  bpr_pkg::frame_ent_t wdata, rdata, ent_r, ent_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic mv_en;
  logic [CW-1:0] mv_pos;

  bpr_ram #(.WIDTH(bpr_pkg::FRAME_W), .DEPTH(bpr_pkg::FRAMES)) u_tbl (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [CW-1:0] limit;
  logic clk_mode, lru_mode;
  logic [SW-1:0] cur_slot;
  logic [32:0] need;
  logic [32:0] ext;
  logic [CW-1:0] n_m1;

  always_comb begin
    limit = (frames_r == '0) ? CW'(1) :
            (frames_r > CW'(bpr_pkg::FRAMES)) ? CW'(bpr_pkg::FRAMES) : frames_r;
    clk_mode = strategy_r == bpr_pkg::STRAT_CLOCK;
    lru_mode = strategy_r == bpr_pkg::STRAT_LRU;
    cur_slot = order_r[cpos_r[SW-1:0]];
    need = {2'b0, req_r.page_number} + 33'd1;
    ext = ({2'b0, req_r.file_pages} < need) ? need - {2'b0, req_r.file_pages} : '0;
    n_m1 = occ_r - CW'(1);
  end

  function automatic logic [bpr_pkg::TOT_W-1:0] sat_add(
    input logic [bpr_pkg::TOT_W-1:0] a, input logic [32:0] b);
    logic [33:0] s;
    begin
      s = {2'b0, a} + {1'b0, b};
      sat_add = (s[33:32] != 2'b0) ? '1 : s[31:0];
    end
  endfunction

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  always_comb begin
    state_nxt = state_r;
    occ_nxt = occ_r; hand_nxt = hand_r;
    reads_nxt = reads_r; writes_nxt = writes_r;
    res_nxt = res_r; out_valid_nxt = out_valid_r;
    pos_nxt = pos_r; cpos_nxt = cpos_r; rvalid_nxt = 1'b0;
    steps_nxt = steps_r; hitpos_nxt = hitpos_r; found_nxt = found_r;
    err_nxt = err_r; clr_nxt = clr_r; ent_nxt = ent_r; slot_nxt = slot_r;
    we = 1'b0; waddr = slot_r; wdata = ent_r; raddr = '0;
    mv_en = 1'b0; mv_pos = hitpos_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        we = 1'b1; waddr = clr_r;
        wdata = '{page: bpr_pkg::NO_PAGE, pins: '0, dirty: 1'b0, refb: 1'b0};
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(bpr_pkg::FRAMES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          res_nxt = '0;
          res_nxt.last = 1'b1;
          pos_nxt = '0; found_nxt = 1'b0; err_nxt = 1'b0; steps_nxt = '0;
          state_nxt = (in_data.action == bpr_pkg::ACT_FLUSH) ? S_FLUSH : S_FIND;
        end
      end
      S_FIND: begin
        // issue a read per position, compare when it returns
        if (pos_r < occ_r && !found_r) begin
          raddr = order_r[pos_r[SW-1:0]];
          cpos_nxt = pos_r; rvalid_nxt = 1'b1; pos_nxt = pos_r + CW'(1);
        end
        if (rvalid_r && !found_r && rdata.page == {1'b0, req_r.page_number}) begin
          found_nxt = 1'b1; hitpos_nxt = cpos_r; ent_nxt = rdata; slot_nxt = cur_slot;
          rvalid_nxt = 1'b0;
        end else if (!rvalid_r && (pos_r >= occ_r || found_r)) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        res_nxt.frame = slot_r;
        state_nxt = S_OUT;
        if (found_r) begin
          we = 1'b1;
          unique case (req_r.action)
            bpr_pkg::ACT_PIN: begin
              res_nxt.hit = 1'b1;
              if (ent_r.pins != '1) wdata.pins = ent_r.pins + 16'd1;
              if (clk_mode) wdata.refb = 1'b1;
              if (lru_mode) mv_en = 1'b1;
            end
            bpr_pkg::ACT_UNPIN: begin
              if (ent_r.pins != '0) wdata.pins = ent_r.pins - 16'd1;
            end
            default: wdata.dirty = 1'b1;
          endcase
        end else if (req_r.action != bpr_pkg::ACT_PIN) begin
          res_nxt.status = bpr_pkg::ST_NOT_FOUND;
          res_nxt.frame = '0;
        end else if (occ_r < limit) begin
          we = 1'b1; waddr = order_r[occ_r[SW-1:0]];
          wdata = '{page: {1'b0, req_r.page_number}, pins: 16'd1, dirty: 1'b0, refb: 1'b0};
          res_nxt.frame = order_r[occ_r[SW-1:0]];
          res_nxt.fetch = 1'b1;
          reads_nxt = sat_add(reads_r, 33'd1);
          writes_nxt = sat_add(writes_r, ext);
          occ_nxt = occ_r + CW'(1);
          if (clk_mode) hand_nxt = (occ_r + CW'(1) < limit) ? occ_r[SW-1:0] + SW'(1) : '0;
        end else begin
          res_nxt.frame = '0;
          pos_nxt = clk_mode ? ((CW'(hand_r) >= occ_r) ? '0 : CW'(hand_r)) : '0;
          steps_nxt = '0;
          state_nxt = clk_mode ? S_SWEEP : S_VICT;
        end
      end
      S_VICT: begin
        if (pos_r < occ_r && !found_r) begin
          raddr = order_r[pos_r[SW-1:0]];
          cpos_nxt = pos_r; rvalid_nxt = 1'b1; pos_nxt = pos_r + CW'(1);
        end
        if (rvalid_r && !found_r && rdata.pins == '0) begin
          found_nxt = 1'b1; hitpos_nxt = cpos_r; ent_nxt = rdata; slot_nxt = cur_slot;
          rvalid_nxt = 1'b0;
        end else if (!rvalid_r && (pos_r >= occ_r || found_r)) begin
          state_nxt = S_OUT;
          if (!found_r) begin
            res_nxt.status = bpr_pkg::ST_NO_ROOM;
          end else begin
            we = 1'b1;
            wdata = '{page: {1'b0, req_r.page_number}, pins: 16'd1, dirty: 1'b0, refb: 1'b0};
            mv_en = 1'b1;
            res_nxt.frame = slot_r; res_nxt.fetch = 1'b1;
            res_nxt.write_back = ent_r.dirty;
            res_nxt.write_page = ent_r.dirty ? ent_r.page[30:0] : '0;
            reads_nxt = sat_add(reads_r, 33'd1);
            writes_nxt = sat_add(writes_r, ext + {32'd0, ent_r.dirty});
          end
        end
      end
      S_SWEEP: begin
        // each position is read, then decided on, clearing its reference bit if it is passed over
        if (!rvalid_r) begin
          if (steps_r >= {1'b0, occ_r, 1'b0}) begin
            res_nxt.status = bpr_pkg::ST_NO_ROOM;
            hand_nxt = pos_r[SW-1:0];
            state_nxt = S_OUT;
          end else begin
            raddr = order_r[pos_r[SW-1:0]];
            cpos_nxt = pos_r; rvalid_nxt = 1'b1;
          end
        end else begin
          if (!rdata.refb && rdata.pins == '0) begin
            we = 1'b1; waddr = cur_slot;
            wdata = '{page: {1'b0, req_r.page_number}, pins: 16'd1, dirty: 1'b0, refb: 1'b1};
            res_nxt.frame = cur_slot; res_nxt.fetch = 1'b1;
            res_nxt.write_back = rdata.dirty;
            res_nxt.write_page = rdata.dirty ? rdata.page[30:0] : '0;
            reads_nxt = sat_add(reads_r, 33'd1);
            writes_nxt = sat_add(writes_r, ext + {32'd0, rdata.dirty});
            hand_nxt = (pos_r + CW'(1) < occ_r) ? pos_r[SW-1:0] + SW'(1) : '0;
            state_nxt = S_OUT;
          end else begin
            we = 1'b1; waddr = cur_slot; wdata = rdata; wdata.refb = 1'b0;
            pos_nxt = (pos_r + CW'(1) < occ_r) ? pos_r + CW'(1) : '0;
            steps_nxt = steps_r + (CW+2)'(1);
          end
        end
      end
      S_FLUSH: begin
        if (!out_valid_r || out_ready) begin
          if (!rvalid_r) begin
            if (pos_r >= occ_r) begin
              state_nxt = S_SUM;
            end else begin
              raddr = order_r[pos_r[SW-1:0]];
              cpos_nxt = pos_r; rvalid_nxt = 1'b1; pos_nxt = pos_r + CW'(1);
            end
          end else if (rdata.dirty) begin
            if (rdata.pins != '0) begin
              err_nxt = 1'b1;
            end else begin
              we = 1'b1; waddr = cur_slot; wdata = rdata; wdata.dirty = 1'b0;
              writes_nxt = sat_add(writes_r, 33'd1);
              res_nxt = '0;
              res_nxt.frame = cur_slot; res_nxt.write_back = 1'b1;
              res_nxt.write_page = rdata.page[30:0];
              res_nxt.reads_total = reads_r;
              res_nxt.writes_total = writes_nxt;
              out_valid_nxt = 1'b1;
            end
          end
        end else if (rvalid_r) begin
          rvalid_nxt = 1'b1;
          raddr = order_r[cpos_r[SW-1:0]];
        end
      end
      S_SUM: begin
        if (!out_valid_r || out_ready) begin
          res_nxt = '0;
          res_nxt.last = 1'b1;
          res_nxt.status = err_r ? bpr_pkg::ST_FLUSH_ERR : bpr_pkg::ST_OK;
          res_nxt.reads_total = reads_r; res_nxt.writes_total = writes_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        res_nxt.reads_total = reads_r; res_nxt.writes_total = writes_r;
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      strategy_r <= bpr_pkg::STRAT_FIFO;
      frames_r <= CW'(bpr_pkg::FRAMES);
      occ_r <= '0; hand_r <= '0; reads_r <= '0; writes_r <= '0;
      out_valid_r <= 1'b0; rvalid_r <= 1'b0; clr_r <= '0;
      for (int i = 0; i < bpr_pkg::FRAMES; i++) order_r[i] <= SW'(i);
    end else begin
      state_r <= state_nxt;
      occ_r <= occ_nxt; hand_r <= hand_nxt;
      reads_r <= reads_nxt; writes_r <= writes_nxt;
      out_valid_r <= out_valid_nxt; rvalid_r <= rvalid_nxt; clr_r <= clr_nxt;
      if (cfg_we) begin
        if (cfg_index == bpr_pkg::REG_STRATEGY) strategy_r <= cfg_data[1:0];
        else frames_r <= cfg_data;
      end
      // move to tail of the filled part of the order list
      if (mv_en) begin
        for (int i = 0; i < bpr_pkg::FRAMES - 1; i++) begin
          if (CW'(i) >= mv_pos && CW'(i) < n_m1) order_r[i] <= order_r[i + 1];
        end
        if (occ_r != '0 && mv_pos < n_m1) order_r[n_m1[SW-1:0]] <= order_r[mv_pos[SW-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    res_r <= res_nxt;
    pos_r <= pos_nxt; cpos_r <= cpos_nxt; steps_r <= steps_nxt;
    hitpos_r <= hitpos_nxt; found_r <= found_nxt; err_r <= err_nxt;
    ent_r <= ent_nxt; slot_r <= slot_nxt;
  end

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(bpr_pkg::FRAMES)) else $error("occupancy above frame count");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
  a_flush_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.write_back && !out_data.fetch) |-> !out_data.last)
    else $error("flush write-back marked last");
`endif
endmodule

>>> bench/tb_buffer_pool_page_replacement.sv
// testbench: random and directed checks of the page replacement block against a predictor
`timescale 1ns / 100ps

module tb_buffer_pool_page_replacement;

  localparam longint TOTAL_SAT = 64'hFFFF_FFFF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bpr_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpr_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [bpr_pkg::CNT_W-1:0] cfg_data = '0;

  buffer_pool_page_replacement DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // predictor state
  logic [1:0] pol;
  logic [4:0] frames_reg;
  logic [31:0] fpage [bpr_pkg::FRAMES];
  logic [15:0] pins [bpr_pkg::FRAMES];
  bit dirty [bpr_pkg::FRAMES];
  bit refb [bpr_pkg::FRAMES];
  int order [bpr_pkg::FRAMES];
  int occ;
  int hand;
  longint reads_cnt;
  longint writes_cnt;

  bpr_pkg::in_item_t request_q[$];
  bpr_pkg::out_item_t predicted_resp_q[$];

  int fails = 0;
  int items_sent = 0;
  int items_queued = 0;
  int resp_seen = 0;
  int cycles = 0;
  bit no_gaps = 1'b0;
  int long_req = 0;
  int long_ack = 0;

  function automatic void add_sat(ref longint c, input longint v);
    c = c + v;
    if (c > TOTAL_SAT) c = TOTAL_SAT;
  endfunction

  function automatic void emit(logic [1:0] st, int fr, bit h, bit f, bit wb,
                               logic [31:0] wpage, bit lst);
    bpr_pkg::out_item_t r;
    r.status = st;
    r.frame = fr[bpr_pkg::SLOT_W-1:0];
    r.hit = h;
    r.fetch = f;
    r.write_back = wb;
    r.write_page = wpage[bpr_pkg::PAGE_W-1:0];
    r.last = lst;
    r.reads_total = reads_cnt[31:0];
    r.writes_total = writes_cnt[31:0];
    predicted_resp_q.push_back(r);
  endfunction

  function automatic int find_pos(logic [30:0] pg);
    for (int p = 0; p < occ; p++)
      if (fpage[order[p]] == {1'b0, pg}) return p;
    return -1;
  endfunction

  function automatic void move_to_tail(int p);
    int s;
    s = order[p];
    if (occ == 0 || p + 1 >= occ) return;
    for (int i = p; i < occ - 1; i++) order[i] = order[i+1];
    order[occ-1] = s;
  endfunction

  function automatic void load_frame(int slot, logic [30:0] pg, logic [30:0] fp);
    longint need;
    need = longint'(pg) + 1;
    if (longint'(fp) < need) add_sat(writes_cnt, need - longint'(fp));
    add_sat(reads_cnt, 1);
    fpage[slot] = {1'b0, pg};
    pins[slot] = 16'd1;
    dirty[slot] = 1'b0;
    refb[slot] = 1'b0;
  endfunction

  function automatic void pin_page(logic [30:0] pg, logic [30:0] fp);
    int lim, n, p, slot, steps, hp;
    bit clk_pol, lru, wb;
    logic [31:0] wpage;
    lim = (frames_reg == 0) ? 1 :
          ((frames_reg > bpr_pkg::FRAMES) ? bpr_pkg::FRAMES : frames_reg);
    n = occ;
    clk_pol = (pol == bpr_pkg::STRAT_CLOCK);
    lru = (pol == bpr_pkg::STRAT_LRU);
    hp = find_pos(pg);
    if (hp >= 0) begin
      slot = order[hp];
      if (pins[slot] != 16'hFFFF) pins[slot]++;
      if (lru) move_to_tail(hp);
      if (clk_pol) refb[slot] = 1'b1;
      emit(bpr_pkg::ST_OK, slot, 1, 0, 0, 0, 1);
      return;
    end
    if (n < lim) begin
      slot = order[n];
      load_frame(slot, pg, fp);
      occ = n + 1;
      if (clk_pol) hand = (occ < lim) ? occ : 0;
      emit(bpr_pkg::ST_OK, slot, 0, 1, 0, 0, 1);
      return;
    end
    if (!clk_pol) begin
      for (p = 0; p < n; p++)
        if (pins[order[p]] == 0) break;
      if (p >= n) begin
        emit(bpr_pkg::ST_NO_ROOM, 0, 0, 0, 0, 0, 1);
        return;
      end
    end else begin
      if (hand >= n) hand = 0;
      for (steps = 0; steps < 2 * n; steps++) begin
        slot = order[hand];
        if (!refb[slot] && pins[slot] == 0) break;
        refb[slot] = 1'b0;
        hand = (hand + 1 < n) ? hand + 1 : 0;
      end
      if (steps >= 2 * n) begin
        emit(bpr_pkg::ST_NO_ROOM, 0, 0, 0, 0, 0, 1);
        return;
      end
      p = hand;
    end
    slot = order[p];
    wb = dirty[slot];
    wpage = fpage[slot];
    if (wb) add_sat(writes_cnt, 1);
    load_frame(slot, pg, fp);
    if (clk_pol) begin
      refb[slot] = 1'b1;
      hand = (hand + 1 < n) ? hand + 1 : 0;
    end else begin
      move_to_tail(p);
    end
    emit(bpr_pkg::ST_OK, slot, 0, 1, wb, wb ? wpage : 32'd0, 1);
  endfunction

  function automatic void model_request(bpr_pkg::in_item_t it);
    int slot, hp;
    bit err;
    err = 1'b0;
    case (it.action)
      bpr_pkg::ACT_PIN: pin_page(it.page_number, it.file_pages);
      bpr_pkg::ACT_FLUSH: begin
        for (int p = 0; p < occ; p++) begin
          slot = order[p];
          if (dirty[slot]) begin
            if (pins[slot] != 0) begin
              err = 1'b1;
            end else begin
              add_sat(writes_cnt, 1);
              dirty[slot] = 1'b0;
              emit(bpr_pkg::ST_OK, slot, 0, 0, 1, fpage[slot], 0);
            end
          end
        end
        emit(err ? bpr_pkg::ST_FLUSH_ERR : bpr_pkg::ST_OK, 0, 0, 0, 0, 0, 1);
      end
      default: begin
        hp = find_pos(it.page_number);
        if (hp < 0) begin
          emit(bpr_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 0, 1);
        end else begin
          slot = order[hp];
          if (it.action == bpr_pkg::ACT_UNPIN) begin
            if (pins[slot] > 0) pins[slot]--;
          end else begin
            dirty[slot] = 1'b1;
          end
          emit(bpr_pkg::ST_OK, slot, 0, 0, 0, 0, 1);
        end
      end
    endcase
  endfunction

  function automatic int draw_gap();
    return no_gaps ? 0 : $urandom_range(0, 19);
  endfunction

  // sender
  int send_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        model_request(in_data);
        items_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          in_data <= request_q.pop_front();
          in_valid <= 1'b1;
          send_gap <= draw_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic cmp_field(string nm, longint e, longint a);
    if (e != a) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
      fails++;
    end
  endtask

  // receiver and checker
  int stall = 0;
  always @(posedge clk) begin
    int n;
    bpr_pkg::out_item_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else begin
      if (out_valid && out_ready) begin
        resp_seen++;
        if (predicted_resp_q.size() == 0) begin
          $display("%0t unexpected transaction: expected none actual %h", $time, out_data);
          fails++;
        end else begin
          e = predicted_resp_q.pop_front();
          cmp_field("status", e.status, out_data.status);
          cmp_field("frame", e.frame, out_data.frame);
          cmp_field("hit", e.hit, out_data.hit);
          cmp_field("fetch", e.fetch, out_data.fetch);
          cmp_field("write_back", e.write_back, out_data.write_back);
          cmp_field("write_page", e.write_page, out_data.write_page);
          cmp_field("last", e.last, out_data.last);
          cmp_field("reads_total", e.reads_total, out_data.reads_total);
          cmp_field("writes_total", e.writes_total, out_data.writes_total);
        end
      end
      if (long_ack != long_req) begin
        long_ack <= long_req;
        stall <= 400;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        n = draw_gap();
        stall <= n;
        out_ready <= (n == 0);
      end else if (stall > 0) begin
        stall <= stall - 1;
        out_ready <= (stall == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("buffer_pool_page_replacement test failed");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [4:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bpr_pkg::REG_STRATEGY) pol = val[1:0];
    else frames_reg = val;
  endtask

  task automatic queue_item(logic [1:0] act, logic [30:0] pg, logic [30:0] fp);
    bpr_pkg::in_item_t it;
    it.action = act;
    it.page_number = pg;
    it.file_pages = fp;
    request_q.push_back(it);
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_sent != items_queued || predicted_resp_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic bpr_pkg::in_item_t rand_item(int span);
    bpr_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.action = (r < 50) ? bpr_pkg::ACT_PIN : (r < 75) ? bpr_pkg::ACT_UNPIN :
                (r < 92) ? bpr_pkg::ACT_DIRTY : bpr_pkg::ACT_FLUSH;
    if ($urandom_range(0, 19) == 0) it.page_number = 31'($urandom());
    else it.page_number = 31'($urandom_range(0, span));
    case ($urandom_range(0, 3))
      0: it.file_pages = 31'($urandom());
      1: it.file_pages = '0;
      default: it.file_pages = 31'(it.page_number + $urandom_range(0, 3));
    endcase
    return it;
  endfunction

  task automatic run_phase(logic [1:0] strat, logic [4:0] frames, int count, bit bursty,
                           bit hold);
    write_reg(bpr_pkg::REG_STRATEGY, {3'b0, strat});
    write_reg(bpr_pkg::REG_FRAMES, frames);
    no_gaps = bursty;
    if (hold) long_req++;
    for (int i = 0; i < count; i++) begin
      request_q.push_back(rand_item(frames + 4));
      items_queued++;
    end
    wait_idle();
  endtask

  initial begin
    pol = bpr_pkg::STRAT_FIFO;
    frames_reg = 5'd16;
    for (int i = 0; i < bpr_pkg::FRAMES; i++) begin
      fpage[i] = bpr_pkg::NO_PAGE;
      pins[i] = '0;
      dirty[i] = 1'b0;
      refb[i] = 1'b0;
      order[i] = i;
    end
    occ = 0;
    hand = 0;
    reads_cnt = 0;
    writes_cnt = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: two frames under fifo
    write_reg(bpr_pkg::REG_STRATEGY, {3'b0, bpr_pkg::STRAT_FIFO});
    write_reg(bpr_pkg::REG_FRAMES, 5'd2);
    queue_item(bpr_pkg::ACT_FLUSH, 0, 0);
    queue_item(bpr_pkg::ACT_UNPIN, 5, 0);
    queue_item(bpr_pkg::ACT_DIRTY, 5, 0);
    queue_item(bpr_pkg::ACT_PIN, 31'h7FFF_FFFF, 0);
    queue_item(bpr_pkg::ACT_PIN, 31'h7FFF_FFFE, 0);
    queue_item(bpr_pkg::ACT_PIN, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    queue_item(bpr_pkg::ACT_PIN, 3, 31'h7FFF_FFFF);
    queue_item(bpr_pkg::ACT_DIRTY, 31'h7FFF_FFFE, 0);
    queue_item(bpr_pkg::ACT_FLUSH, 0, 0);
    queue_item(bpr_pkg::ACT_UNPIN, 31'h7FFF_FFFE, 0);
    queue_item(bpr_pkg::ACT_UNPIN, 31'h7FFF_FFFE, 0);
    queue_item(bpr_pkg::ACT_FLUSH, 0, 0);
    queue_item(bpr_pkg::ACT_DIRTY, 31'h7FFF_FFFE, 0);
    queue_item(bpr_pkg::ACT_PIN, 9, 2);
    queue_item(bpr_pkg::ACT_UNPIN, 31'h7FFF_FFFF, 0);
    queue_item(bpr_pkg::ACT_UNPIN, 31'h7FFF_FFFF, 0);
    queue_item(bpr_pkg::ACT_PIN, 0, 0);
    queue_item(bpr_pkg::ACT_PIN, 0, 31'h5555_5555);
    queue_item(bpr_pkg::ACT_UNPIN, 31'h2AAA_AAAA, 31'h2AAA_AAAA);
    wait_idle();

    run_phase(bpr_pkg::STRAT_FIFO, 5'd16, 40, 1'b0, 1'b0);
    run_phase(bpr_pkg::STRAT_LRU, 5'd4, 40, 1'b1, 1'b1);
    run_phase(bpr_pkg::STRAT_CLOCK, 5'd3, 40, 1'b0, 1'b0);
    run_phase(bpr_pkg::STRAT_CLOCK, 5'd31, 40, 1'b0, 1'b0);
    run_phase(2'd3, 5'd0, 35, 1'b1, 1'b0);
    run_phase(bpr_pkg::STRAT_LRU, 5'd1, 35, 1'b0, 1'b0);
    run_phase(bpr_pkg::STRAT_CLOCK, 5'd8, 40, 1'b0, 1'b0);

    $display("covered %0d transactions in, %0d out over fifo, lru, clock and unknown policy",
             items_sent, resp_seen);
    $display("pool sizes from 0 to 31 were set, with bursts and a long receiver hold-off");
    if (fails == 0) begin
      $display("buffer_pool_page_replacement test passed");
    end else begin
      $display("buffer_pool_page_replacement test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/bpr_pkg.sv
src/bpr_ram.sv
src/buffer_pool_page_replacement.sv
bench/tb_buffer_pool_page_replacement.sv
